// ----- sv/gsbs_pkg.sv -----
// Package: item types, register codes and Gold sequence matrix helpers.
`default_nettype none

package gsbs_pkg;

    localparam int REG_BITS      = 31;
    localparam int DATA_BITS     = 32;
    localparam int RNTI_BITS     = 16;
    localparam int CELL_ID_BITS  = 9;
    localparam int SLOT_BITS     = 5;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;
    localparam int WORD_BITS_DEF = 32;
    localparam int unsigned GOLD_NC = 1600;

    typedef logic [REG_BITS-1:0]                t_gvec;
    typedef logic [REG_BITS-1:0][REG_BITS-1:0]  t_gmat;

    // feedback taps: x1 uses x(n)^x(n+3), x2 uses x(n)^..^x(n+3)
    localparam t_gvec TAP_ONE = t_gvec'(4'b1001);
    localparam t_gvec TAP_TWO = t_gvec'(4'b1111);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_RNTI    = 1'b0,
        CFG_CELL_ID = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic                 start_req;
        logic                 frame_parity;
        logic [SLOT_BITS-1:0] slot_number;
        logic [DATA_BITS-1:0] data_word;
        logic                 last;
    } t_in_item;

    typedef struct packed {
        logic [DATA_BITS-1:0] scrambled_word;
        logic                 last_out;
    } t_out_item;

    typedef struct packed {
        t_gvec x1;
        t_gvec x2;
    } t_gold_state;

    // Runs one register forward by a number of steps (elaboration only).
    function automatic t_gvec gold_run(t_gvec tap, t_gvec init, int unsigned steps);
        t_gvec       s;
        logic        fb;
        int unsigned n;
        s = init;
        for (n = 0; n < steps; n++) begin
            fb = ^(s & tap);
            s  = {fb, s[REG_BITS-1:1]};
        end
        return s;
    endfunction

    // Row form of the step^n map: entry [j][i] is bit j of the image of bit i.
    function automatic t_gmat gold_mat(t_gvec tap, int unsigned steps);
        t_gmat m;
        t_gvec v;
        int    i;
        int    j;
        m = '0;
        for (i = 0; i < REG_BITS; i++) begin
            v = gold_run(tap, t_gvec'(1) << i, steps);
            for (j = 0; j < REG_BITS; j++) begin
                m[j][i] = v[j];
            end
        end
        return m;
    endfunction

    // GF(2) matrix times vector; each output bit is an independent parity.
    function automatic t_gvec gold_apply(t_gmat m, t_gvec s);
        t_gvec r;
        int    j;
        for (j = 0; j < REG_BITS; j++) begin
            r[j] = ^(m[j] & s);
        end
        return r;
    endfunction

    localparam t_gvec X1_START = gold_run(TAP_ONE, t_gvec'(1), GOLD_NC);
    localparam t_gmat SEED_ADV = gold_mat(TAP_TWO, GOLD_NC);

endpackage

`default_nettype wire

// ----- sv/gsbs_state.sv -----
// Sequence state: seeding with the 1600-step jump and the per-item word advance.
`default_nettype none

module gsbs_state #(
    parameter int WORD_BITS = gsbs_pkg::WORD_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_take,
    input  wire                                 i_start,
    input  wire                                 i_parity,
    input  wire  [gsbs_pkg::SLOT_BITS-1:0]      i_slot,
    input  wire  [gsbs_pkg::RNTI_BITS-1:0]      i_rnti,
    input  wire  [gsbs_pkg::CELL_ID_BITS-1:0]   i_cell_id,
    output gsbs_pkg::t_gold_state               o_cur
);
    import gsbs_pkg::*;

    localparam t_gmat STEP_ONE = gold_mat(TAP_ONE, WORD_BITS);
    localparam t_gmat STEP_TWO = gold_mat(TAP_TWO, WORD_BITS);

    t_gvec r_x1, n_x1;
    t_gvec r_x2, n_x2;
    t_gvec seed;
    t_gold_state cur;

    // fields never overlap, so the seed sum is a plain concatenation
    assign seed = {1'b0, i_rnti, i_parity, i_slot[SLOT_BITS-1:1], i_cell_id};

    always_comb begin
        cur.x1 = i_start ? X1_START : r_x1;
        cur.x2 = i_start ? gold_apply(SEED_ADV, seed) : r_x2;
        n_x1   = r_x1;
        n_x2   = r_x2;
        if (i_take) begin
            n_x1 = gold_apply(STEP_ONE, cur.x1);
            n_x2 = gold_apply(STEP_TWO, cur.x2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= '0;
            r_x2 <= '0;
        end else begin
            r_x1 <= n_x1;
            r_x2 <= n_x2;
        end
    end

    assign o_cur = cur;

    // x1 is seeded nonzero and a maximal LFSR never reaches zero
    a_x1_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && i_start |=> r_x1 != '0)
        else $error("x1 register zero after seeding");

    a_x1_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_take && i_start) && r_x1 == '0 |=> r_x1 == '0)
        else $error("x1 register left zero without a start item");

endmodule

`default_nettype wire

// ----- sv/gsbs_lane.sv -----
// One lane: sequence bit number LANE of a word from the word's start state.
`default_nettype none

module gsbs_lane #(
    parameter int LANE = 0
) (
    input  gsbs_pkg::t_gold_state i_state,
    output logic                  o_bit
);
    import gsbs_pkg::*;

    localparam t_gmat MAT_ONE = gold_mat(TAP_ONE, LANE);
    localparam t_gmat MAT_TWO = gold_mat(TAP_TWO, LANE);

    // bit 0 after LANE steps, as a parity over the start state
    assign o_bit = ^(MAT_ONE[0] & i_state.x1) ^ ^(MAT_TWO[0] & i_state.x2);

endmodule

`default_nettype wire

// ----- sv/gsbs_merge.sv -----
// Merge stage: gathers lane bits, XORs them onto the data word, output register.
`default_nettype none

module gsbs_merge (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_valid,
    output logic                              o_ready,
    input  wire  [gsbs_pkg::DATA_BITS-1:0]    i_seq,
    input  wire  [gsbs_pkg::DATA_BITS-1:0]    i_data,
    input  wire                               i_last,
    output logic                              o_valid,
    input  wire                               i_ready,
    output gsbs_pkg::t_out_item               o_item
);
    import gsbs_pkg::*;

    logic      r_valid, n_valid;
    t_out_item r_item;
    logic      take;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item.scrambled_word <= i_data ^ i_seq;
            r_item.last_out       <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ----- sv/gold_sequence_bit_scrambler_unit.sv -----
// Pipeline: an accepted item is registered in the state stage, then in the merge
// register, from which the receiver takes the result.
// Throughput: one item per cycle unless the output stalls; the word advance and the seed
// jump are constant GF(2) matrices applied combinationally, so starts cost nothing extra.
// Reset (synchronous, active low): both LFSRs zero, rnti and cell_id zero,
// pipeline empty; the block is ready to take items as soon as reset ends.
`default_nettype none

module gold_sequence_bit_scrambler_unit #(
    parameter int WORD_BITS = gsbs_pkg::WORD_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  gsbs_pkg::t_in_item                   i_in_item,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output gsbs_pkg::t_out_item                  o_out_item,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [gsbs_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire  [gsbs_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import gsbs_pkg::*;

    // only the low min(WORD_BITS, DATA_BITS) sequence bits reach the word; the rest are zero
    localparam int LANES = (WORD_BITS < DATA_BITS) ? WORD_BITS : DATA_BITS;

    logic [RNTI_BITS-1:0]    r_rnti;
    logic [CELL_ID_BITS-1:0] r_cell_id;

    logic                 r_s1_valid, n_s1_valid;
    t_gold_state          r_s1_state;
    logic [DATA_BITS-1:0] r_s1_data;
    logic                 r_s1_last;

    t_gold_state          cur;
    logic [DATA_BITS-1:0] seq;
    logic                 s1_adv;
    logic                 in_take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnti    <= '0;
            r_cell_id <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_RNTI:    r_rnti    <= i_cfg_data[RNTI_BITS-1:0];
                CFG_CELL_ID: r_cell_id <= i_cfg_data[CELL_ID_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_take    = i_in_valid && o_in_ready;

    gsbs_state #(
        .WORD_BITS (WORD_BITS)
    ) u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (in_take),
        .i_start   (i_in_item.start_req),
        .i_parity  (i_in_item.frame_parity),
        .i_slot    (i_in_item.slot_number),
        .i_rnti    (r_rnti),
        .i_cell_id (r_cell_id),
        .o_cur     (cur)
    );

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_take) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_state <= cur;
            r_s1_data  <= i_in_item.data_word;
            r_s1_last  <= i_in_item.last;
        end
    end

    for (genvar k = 0; k < DATA_BITS; k++) begin : g_lane
        if (k < LANES) begin : g_on
            gsbs_lane #(
                .LANE (k)
            ) u_lane (
                .i_state (r_s1_state),
                .o_bit   (seq[k])
            );
        end else begin : g_off
            assign seq[k] = 1'b0;
        end
    end

    gsbs_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .o_ready (s1_adv),
        .i_seq   (seq),
        .i_data  (r_s1_data),
        .i_last  (r_s1_last),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid)
        else $error("state stage item dropped while merge stalled");

    a_s1_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_s1_valid)
        else $error("accepted item missing from state stage");

endmodule

`default_nettype wire

// ----- bench/tb_gold_sequence_bit_scrambler_unit.sv -----
// Testbench for the Gold sequence bit scrambler: sequence predictor, stimulus and result checks.
module tb_gold_sequence_bit_scrambler_unit;
    import gsbs_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int LONG_HOLD     = 60;
    localparam int SEED_ADVANCE  = 1600;
    localparam int SETTLE_CYCLES = 8;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    t_in_item                 i_in_item;
    logic                     o_out_valid;
    logic                     i_out_ready;
    t_out_item                o_out_item;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    // predictor state and its copy of the registers
    logic [REG_BITS-1:0]     x1_state;
    logic [REG_BITS-1:0]     x2_state;
    logic [RNTI_BITS-1:0]    rnti_cfg;
    logic [CELL_ID_BITS-1:0] cell_id_cfg;

    t_out_item expected_words[$];
    int        error_count;
    bit        idle_on;
    int        hold_token;
    int        hold_seen;
    int        stall_left;
    longint    cycle_count;

    gold_sequence_bit_scrambler_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // One step of both registers; returns the sequence bit taken before the shift.
    function automatic logic gold_advance();
        logic seq_bit;
        logic fb1;
        logic fb2;
        seq_bit  = x1_state[0] ^ x2_state[0];
        fb1      = x1_state[0] ^ x1_state[3];
        fb2      = x2_state[0] ^ x2_state[1] ^ x2_state[2] ^ x2_state[3];
        x1_state = {fb1, x1_state[REG_BITS-1:1]};
        x2_state = {fb2, x2_state[REG_BITS-1:1]};
        return seq_bit;
    endfunction

    function automatic t_out_item scramble_predict(t_in_item it);
        logic [31:0]          seed;
        logic [DATA_BITS-1:0] seq;
        t_out_item            r;
        if (it.start_req) begin
            seed = (32'(rnti_cfg) << 14) + (32'(it.frame_parity) << 13)
                 + (32'(it.slot_number >> 1) << 9) + 32'(cell_id_cfg);
            x1_state = 31'd1;
            x2_state = seed[REG_BITS-1:0];
            repeat (SEED_ADVANCE) void'(gold_advance());
        end
        for (int k = 0; k < DATA_BITS; k++) begin
            seq[k] = gold_advance();
        end
        r.scrambled_word = it.data_word ^ seq;
        r.last_out       = it.last;
        return r;
    endfunction

    function automatic t_in_item word_of(bit start, bit parity, logic [SLOT_BITS-1:0] slot,
                                         logic [DATA_BITS-1:0] data, bit last);
        t_in_item it;
        it.start_req    = start;
        it.frame_parity = parity;
        it.slot_number  = slot;
        it.data_word    = data;
        it.last         = last;
        return it;
    endfunction

    function automatic t_in_item make_word(bit start, bit last);
        logic [SLOT_BITS-1:0] slot;
        logic [DATA_BITS-1:0] data;
        // mostly legal slots, now and then the unused codes
        slot = ($urandom_range(0, 7) == 0) ? SLOT_BITS'($urandom_range(20, 31))
                                           : SLOT_BITS'($urandom_range(0, 19));
        case ($urandom_range(0, 9))
            0:       data = '0;
            1:       data = '1;
            default: data = $urandom;
        endcase
        return word_of(start, 1'($urandom_range(0, 1)), slot, data, last);
    endfunction

    task automatic send_word(input t_in_item it);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge i_clk) i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        expected_words.push_back(scramble_predict(it));
    endtask

    task automatic wait_drained();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_RNTI:    rnti_cfg    = data;
            CFG_CELL_ID: cell_id_cfg = data[CELL_ID_BITS-1:0];
            default: begin
            end
        endcase
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [CFG_DATA_BITS-1:0] rnti,
                             input logic [CFG_DATA_BITS-1:0] cell_id);
        wait_drained();
        write_reg(CFG_RNTI, rnti);
        write_reg(CFG_CELL_ID, cell_id);
    endtask

    // Registers are zero out of reset, so unseeded words pass through untouched.
    task automatic test_reset_passthrough();
        send_word(word_of(1'b0, 1'b0, 5'd0, 32'h0000_0000, 1'b0));
        send_word(word_of(1'b0, 1'b1, 5'd31, 32'hFFFF_FFFF, 1'b1));
        send_word(word_of(1'b0, 1'b0, 5'd7, 32'hA5A5_5A5A, 1'b0));
    endtask

    task automatic test_seed_extremes();
        configure(16'h0000, 16'h0000);
        send_word(word_of(1'b1, 1'b0, 5'd0, 32'h0000_0000, 1'b0));
        send_word(word_of(1'b0, 1'b0, 5'd0, 32'h0000_0000, 1'b0));
        send_word(word_of(1'b0, 1'b1, 5'd3, 32'hFFFF_FFFF, 1'b1));
        // sequence keeps running across a last word
        send_word(word_of(1'b0, 1'b0, 5'd0, 32'h0000_0000, 1'b0));
        send_word(word_of(1'b0, 1'b0, 5'd0, 32'h1234_5678, 1'b1));
        configure(16'hFFFF, 16'd503);
        send_word(word_of(1'b1, 1'b1, 5'd19, 32'hFFFF_FFFF, 1'b1));
        send_word(word_of(1'b1, 1'b0, 5'd18, 32'h0000_0000, 1'b0));
        // restart in the middle of a block
        send_word(word_of(1'b1, 1'b1, 5'd1, 32'h5A5A_A5A5, 1'b1));
        // cell id beyond the legal range, upper data bits set as well
        configure(16'hFFFF, 16'hFFFF);
        send_word(word_of(1'b1, 1'b1, 5'd31, 32'h0000_0000, 1'b0));
        send_word(word_of(1'b1, 1'b0, 5'd20, 32'hFFFF_FFFF, 1'b1));
        configure(16'h8001, 16'h0100);
        send_word(word_of(1'b1, 1'b0, 5'd30, 32'h8000_0001, 1'b0));
        send_word(word_of(1'b0, 1'b1, 5'd0, 32'h7FFF_FFFE, 1'b1));
        send_word(word_of(1'b1, 1'b1, 5'd10, 32'hDEAD_BEEF, 1'b1));
    endtask

    task automatic test_random_blocks(input int n_items);
        int sent;
        int len;
        int r;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 9);
            if (r < 8) begin
                len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 16);
                for (int k = 0; k < len; k++) send_word(make_word(k == 0, k == len - 1));
                sent += len;
            end else if (r == 8) begin
                send_word(make_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
                sent++;
            end else begin
                // block cut short; the next start reseeds
                len = $urandom_range(1, 5);
                for (int k = 0; k < len; k++) send_word(make_word(k == 0, 1'b0));
                sent += len;
            end
        end
    endtask

    // Receiver holds off while the sender keeps offering items.
    task automatic test_output_backpressure();
        hold_token++;
        test_random_blocks(40);
    endtask

    task automatic test_sender_pause();
        for (int n = 0; n < 3; n++) begin
            send_word(make_word(1'b1, 1'b0));
            for (int k = 0; k < 4; k++) send_word(make_word(1'b0, 1'b0));
            wait_drained();
            for (int k = 0; k < 5; k++) send_word(make_word(1'b0, k == 4));
        end
    endtask

    task automatic test_full_rate();
        configure(CFG_DATA_BITS'($urandom), CFG_DATA_BITS'($urandom));
        idle_on = 1'b0;
        test_random_blocks(200);
    endtask

    // receiver: random stall bursts, plus one long hold per request
    initial begin
        i_out_ready = 1'b0;
        hold_seen   = 0;
        stall_left  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_token != hold_seen) begin
                hold_seen  = hold_token;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                stall_left = $urandom_range(1, 4) - 1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                $error("result item with nothing pending: scrambled_word %h last_out %b",
                       o_out_item.scrambled_word, o_out_item.last_out);
                error_count++;
            end else begin
                want = expected_words.pop_front();
                if (o_out_item.scrambled_word !== want.scrambled_word) begin
                    $error("scrambled_word expected %h actual %h",
                           want.scrambled_word, o_out_item.scrambled_word);
                    error_count++;
                end
                if (o_out_item.last_out !== want.last_out) begin
                    $error("last_out expected %b actual %b", want.last_out, o_out_item.last_out);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("gold_sequence_bit_scrambler_unit verification failed");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        x1_state    = '0;
        x2_state    = '0;
        rnti_cfg    = '0;
        cell_id_cfg = '0;
        error_count = 0;
        hold_token  = 0;
        cycle_count = 0;
        idle_on     = 1'b1;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        test_reset_passthrough();
        test_seed_extremes();
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       configure(16'h0000, 16'h0000);
                1:       configure(16'hFFFF, 16'd503);
                2:       configure(16'hFFFF, 16'hFFFF);
                3:       configure(16'h0000, 16'd503);
                default: configure(CFG_DATA_BITS'($urandom),
                                   CFG_DATA_BITS'($urandom_range(0, 16'hFFFF)));
            endcase
            test_random_blocks(150);
        end
        test_output_backpressure();
        test_sender_pause();
        test_full_rate();
        wait_drained();

        if (error_count == 0) begin
            $display("gold_sequence_bit_scrambler_unit verification clean");
        end else begin
            $display("gold_sequence_bit_scrambler_unit verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/gsbs_pkg.sv
sv/gsbs_state.sv
sv/gsbs_lane.sv
sv/gsbs_merge.sv
sv/gold_sequence_bit_scrambler_unit.sv
bench/tb_gold_sequence_bit_scrambler_unit.sv
